/* hw/rtl/prbm_pkg.sv */
package prbm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = 16;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = 55;
   localparam int CNT_W       = 25;
   localparam int MAX_SAMPLES = 16777216;
   localparam int FSIZE_W     = 26;
   localparam int KBPS_NUM    = 3528;
   localparam int KBPS_NUM_W  = 12;
   localparam int PROD_W      = FSIZE_W + KBPS_NUM_W;
   localparam int KBPS_W      = 16;
   localparam int DIVR_W      = 27;
   localparam int REM_W       = DIVR_W;
   localparam int SUB_W       = REM_W + 1;
   localparam int ROOT_W      = 16;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;

   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;
   localparam logic [ADDR_W-3:0] REG_FILE_SIZE = '0;

   localparam logic [KBPS_W-1:0] KBPS_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_RATE,
      ST_RATE_DIV,
      ST_LOAD_MEAN,
      ST_MEAN_DIV,
      ST_LOAD_SQRT,
      ST_SQRT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic load_rate;
      logic rate_step;
      logic load_mean;
      logic mean_step;
      logic load_sqrt;
      logic sqrt_step;
      logic finish;
   } ctrl_type;

endpackage

/* hw/rtl/peak_rms_bitrate_meter.sv */
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     req_sample, req_last
// rsp      out        rsp_valid / rsp_stall     rsp_peak_level, rsp_rms_level, rsp_bitrate_kbps
// csr      in         APB write/read, 1 reg     file_size_bytes at byte address 0
//
// Samples without last are taken one per cycle: one register stage for the
// magnitude, then the square and accumulate.
// After the last item the block stalls while one shared 28-bit
// subtractor runs a 55-step bitrate divide, a 55-step mean divide, then a
// 16-step square root. The result sits in an output register; a waiting result
// stalls only the next stream end. Reset is synchronous and clears all stream
// state and the file size register.
module peak_rms_bitrate_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [prbm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [prbm_pkg::MAG_W-1:0]      rsp_peak_level,
   output logic        [prbm_pkg::ROOT_W-1:0]     rsp_rms_level,
   output logic        [prbm_pkg::KBPS_W-1:0]     rsp_bitrate_kbps,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [prbm_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic        [prbm_pkg::DATA_W-1:0]     csr_pwdata,
   output logic        [prbm_pkg::DATA_W-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import prbm_pkg::*;

   state_type            state_ff, state_in;
   ctrl_type             ctrl;

   logic [FSIZE_W-1:0]   fsize_ff;
   logic                 reg_hit;

   logic                 req_accept;
   logic [SAMPLE_W-1:0]  raw;
   logic [MAG_W-1:0]     sample_mag;
   logic                 s1_valid_ff, s1_last_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [SQ_W-1:0]      square;

   logic [MAG_W-1:0]     peak_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     count_ff;

   logic [PROD_W-1:0]    fs_prod;
   logic [DIVR_W-1:0]    div5;
   logic [SUM_W-1:0]     dq_ff;
   logic [DIVR_W-1:0]    div_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [RAD_W-1:0]     sv_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [KBPS_W-1:0]    rate_ff;

   logic [SUB_W-1:0]     sub_a, sub_b;
   logic [SUB_W:0]       sub_diff;
   logic                 sub_ok;
   logic [REM_W-1:0]     keep_val;

   logic                 rsp_valid_ff;
   logic [MAG_W-1:0]     rsp_peak_ff;
   logic [ROOT_W-1:0]    rsp_rms_ff;
   logic [KBPS_W-1:0]    rsp_rate_ff;

   // configuration port
   assign reg_hit    = (csr_paddr[ADDR_W-1:2] == REG_FILE_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? DATA_W'(fsize_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsize_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         fsize_ff <= csr_pwdata[FSIZE_W-1:0];
      end
   end

   // input stage: magnitude
   assign req_stall  = ctrl.busy;
   assign req_accept = req_valid && !req_stall;
   assign raw        = req_sample;
   assign sample_mag = raw[SAMPLE_W-1] ? (~raw + MAG_W'(1)) : raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mag_ff     <= sample_mag;
         s1_last_ff <= req_last;
      end
   end

   // accumulate
   assign square = SQ_W'(mag_ff) * SQ_W'(mag_ff);

   always_ff @(posedge clock) begin
      if (reset || ctrl.finish) begin
         peak_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (s1_valid_ff) begin
         if (mag_ff > peak_ff) begin
            peak_ff <= mag_ff;
         end
         // count saturates at a full stream; peak still tracks
         if (count_ff < CNT_W'(MAX_SAMPLES)) begin
            sum_ff   <= sum_ff + SUM_W'(square);
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (s1_valid_ff && s1_last_ff) state_in = ST_LOAD_RATE;
         ST_LOAD_RATE: state_in = ST_RATE_DIV;
         ST_RATE_DIV:  if (step_ff == '0) state_in = ST_LOAD_MEAN;
         ST_LOAD_MEAN: state_in = ST_MEAN_DIV;
         ST_MEAN_DIV:  if (step_ff == '0) state_in = ST_LOAD_SQRT;
         ST_LOAD_SQRT: state_in = ST_SQRT;
         ST_SQRT:      if (step_ff == '0) state_in = ST_FINISH;
         ST_FINISH:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:      ctrl.busy = s1_valid_ff && s1_last_ff;
         ST_LOAD_RATE: begin
            ctrl.busy      = 1'b1;
            ctrl.load_rate = 1'b1;
         end
         ST_RATE_DIV:  begin
            ctrl.busy      = 1'b1;
            ctrl.rate_step = 1'b1;
         end
         ST_LOAD_MEAN: begin
            ctrl.busy      = 1'b1;
            ctrl.load_mean = 1'b1;
         end
         ST_MEAN_DIV:  begin
            ctrl.busy      = 1'b1;
            ctrl.mean_step = 1'b1;
         end
         ST_LOAD_SQRT: begin
            ctrl.busy      = 1'b1;
            ctrl.load_sqrt = 1'b1;
         end
         ST_SQRT:      begin
            ctrl.busy      = 1'b1;
            ctrl.sqrt_step = 1'b1;
         end
         ST_FINISH:    begin
            ctrl.busy   = 1'b1;
            ctrl.finish = !rsp_valid_ff || !rsp_stall;
         end
         default:      ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (ctrl.load_rate || ctrl.load_mean) begin
            step_ff <= STEP_W'(DIV_STEPS - 1);
         end else if (ctrl.load_sqrt) begin
            step_ff <= STEP_W'(SQRT_STEPS - 1);
         end else if (ctrl.rate_step || ctrl.mean_step || ctrl.sqrt_step) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   // shared subtractor: restoring divide step or root digit step
   always_comb begin
      if (ctrl.sqrt_step) begin
         sub_a = {rem_ff[REM_W-2:0], sv_ff[RAD_W-1 -: 2]};
         sub_b = SUB_W'({root_ff, 2'b01});
      end else begin
         sub_a = {rem_ff, dq_ff[SUM_W-1]};
         sub_b = SUB_W'(div_ff);
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok   = !sub_diff[SUB_W];
   assign keep_val = sub_ok ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];

   assign fs_prod = PROD_W'(fsize_ff) * PROD_W'(KBPS_NUM);
   assign div5    = DIVR_W'({count_ff, 2'b00}) + DIVR_W'(count_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_rate) begin
         dq_ff  <= SUM_W'(fs_prod);
         div_ff <= div5;
         rem_ff <= '0;
      end else if (ctrl.load_mean) begin
         rate_ff <= (|dq_ff[SUM_W-1:KBPS_W]) ? KBPS_MAX : dq_ff[KBPS_W-1:0];
         dq_ff   <= sum_ff;
         div_ff  <= DIVR_W'(count_ff);
         rem_ff  <= '0;
      end else if (ctrl.load_sqrt) begin
         sv_ff   <= dq_ff[RAD_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctrl.rate_step || ctrl.mean_step) begin
         rem_ff <= keep_val;
         dq_ff  <= {dq_ff[SUM_W-2:0], sub_ok};
      end else if (ctrl.sqrt_step) begin
         rem_ff  <= keep_val;
         root_ff <= {root_ff[ROOT_W-2:0], sub_ok};
         sv_ff   <= {sv_ff[RAD_W-3:0], 2'b00};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_peak_ff <= peak_ff;
         rsp_rms_ff  <= root_ff;
         rsp_rate_ff <= rate_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_peak_level   = rsp_peak_ff;
   assign rsp_rms_level    = rsp_rms_ff;
   assign rsp_bitrate_kbps = rsp_rate_ff;

   // checks
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last) |=> req_stall)
      else $error("no stall after last item");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD_MEAN) |-> (count_ff != '0))
      else $error("zero count at mean divide");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count past limit");

   a_mean_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD_SQRT) |-> (dq_ff[SUM_W-1:RAD_W-1] == '0))
      else $error("mean too wide for root");

endmodule

/* tb/testbench.sv */
module testbench;
   import prbm_pkg::*;

   localparam logic [ADDR_W-1:0] FILE_SIZE_ADDR = {REG_FILE_SIZE, 2'b00};
   localparam int BITRATE_DEN = 5;
   localparam int SETTLE_CYCLES = 140;

   typedef struct {
      logic [MAG_W-1:0]  peak;
      logic [ROOT_W-1:0] rms;
      logic [KBPS_W-1:0] kbps;
   } level_result_type;

   typedef enum {SMP_FULL, SMP_QUIET, SMP_EXTREME, SMP_DC} sample_style_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [MAG_W-1:0]           rsp_peak_level;
   logic [ROOT_W-1:0]          rsp_rms_level;
   logic [KBPS_W-1:0]          rsp_bitrate_kbps;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]          csr_paddr = '0;
   logic [DATA_W-1:0]          csr_pwdata = '0;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;

   // running copy of the meter state
   logic [MAG_W-1:0]   acc_peak = '0;
   logic [SUM_W-1:0]   acc_sqsum = '0;
   logic [CNT_W-1:0]   acc_count = '0;
   logic [FSIZE_W-1:0] file_size = '0;

   level_result_type pending_levels[$];

   int  mismatch_count = 0;
   int  samples_sent = 0;
   int  streams_sent = 0;
   int  levels_checked = 0;
   int  size_settings = 0;
   int  hold_cycles = 0;
   bit  calm = 1'b0;

   peak_rms_bitrate_meter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_bitrate_kbps (rsp_bitrate_kbps),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [RAD_W-1:0] v);
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (ROOT_W'(1) << b);
         if (64'(trial) * 64'(trial) <= 64'(v))
            root = trial;
      end
      return root;
   endfunction

   // Fold one accepted sample into the meter state; on last, queue the levels.
   task automatic track_sample(input logic signed [SAMPLE_W-1:0] s, input logic fin);
      int                v;
      logic [MAG_W:0]    mag;
      longint unsigned   mean;
      longint unsigned   rate;
      level_result_type  res;
      v = s;
      mag = (v < 0) ? (MAG_W+1)'(-v) : (MAG_W+1)'(v);
      if (mag > acc_peak)
         acc_peak = mag[MAG_W-1:0];
      // full stream: count saturates, peak still tracks
      if (acc_count < MAX_SAMPLES) begin
         acc_sqsum = acc_sqsum + SUM_W'(mag) * SUM_W'(mag);
         acc_count = acc_count + 1'b1;
      end
      if (fin) begin
         mean = 64'(acc_sqsum) / 64'(acc_count);
         rate = (64'(file_size) * 64'(KBPS_NUM)) / (64'(BITRATE_DEN) * 64'(acc_count));
         if (rate > 64'(KBPS_MAX))
            rate = 64'(KBPS_MAX);
         res.peak = acc_peak;
         res.rms  = floor_sqrt(mean[RAD_W-1:0]);
         res.kbps = rate[KBPS_W-1:0];
         pending_levels.push_back(res);
         acc_peak  = '0;
         acc_sqsum = '0;
         acc_count = '0;
         streams_sent++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Starts and ends just after a rising edge; valid stays high between
   // back-to-back items.
   task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic fin);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= fin;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      track_sample(s, fin);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_style_type style,
                                                                input logic [SAMPLE_W-1:0] dc);
      case (style)
         SMP_FULL:    return SAMPLE_W'($urandom);
         SMP_QUIET:   return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         SMP_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return -16'sd32768;
               1:       return 16'sd32767;
               2:       return -16'sd32767;
               default: return 16'sd0;
            endcase
         end
         default:     return dc;
      endcase
   endfunction

   task automatic send_stream(input int len, input sample_style_type style);
      logic [SAMPLE_W-1:0] dc;
      dc = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++)
         send_item(pick_sample(style, dc), i == len - 1);
   endtask

   // Lower valid and let the block finish every pending stream.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= FILE_SIZE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the file size, then read it back. Upper bits are dropped.
   task automatic set_file_size(input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] rd;
      csr_cycle(1'b1, value, rd);
      file_size = value[FSIZE_W-1:0];
      size_settings++;
      csr_cycle(1'b0, '0, rd);
      if (rd !== DATA_W'(file_size)) begin
         $error("file_size_bytes readback: expected %0d, got %0d", file_size, rd);
         mismatch_count++;
      end
   endtask

   // Result side: random stall runs, plus a long hold-off on request.
   initial begin : rsp_side
      int run;
      int r;
      run = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
            run = 0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (run > 0) begin
            run--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               run = $urandom_range(0, 6);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               run = $urandom_range(20, 80);
            end
         end
      end
   end

   always @(posedge clock) begin
      level_result_type exp_lv;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $error("level result with none expected: peak %0d rms %0d kbps %0d",
                   rsp_peak_level, rsp_rms_level, rsp_bitrate_kbps);
            mismatch_count++;
         end else begin
            exp_lv = pending_levels.pop_front();
            levels_checked++;
            if (rsp_peak_level !== exp_lv.peak) begin
               $error("peak_level: expected %0d, got %0d", exp_lv.peak, rsp_peak_level);
               mismatch_count++;
            end
            if (rsp_rms_level !== exp_lv.rms) begin
               $error("rms_level: expected %0d, got %0d", exp_lv.rms, rsp_rms_level);
               mismatch_count++;
            end
            if (rsp_bitrate_kbps !== exp_lv.kbps) begin
               $error("bitrate_kbps: expected %0d, got %0d", exp_lv.kbps, rsp_bitrate_kbps);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_reset_register();
      logic [DATA_W-1:0] rd;
      csr_cycle(1'b0, '0, rd);
      if (rd !== '0) begin
         $error("file_size_bytes after reset: expected 0, got %0d", rd);
         mismatch_count++;
      end
   endtask

   // Full-scale and zero samples, saturated, zero and tiny bitrates.
   task automatic test_extremes();
      set_file_size(32'hFFFF_FFFF);
      send_item(-16'sd32768, 1'b1);
      send_item(16'sd32767, 1'b1);
      send_item(16'sd0, 1'b1);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd1, 1'b0);
      send_item(16'sd0, 1'b1);
      drain();
      set_file_size(32'h0);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd32767, 1'b0);
      send_item(-16'sd32767, 1'b0);
      send_item(16'sd12345, 1'b1);
      drain();
      set_file_size(32'h1);
      send_item(16'sd32767, 1'b1);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd1, 1'b1);
      drain();
      set_file_size(32'h0001_0000);
      send_item(-16'sd21846, 1'b0);
      send_item(16'sd21845, 1'b0);
      send_item(16'sd100, 1'b1);
      drain();
   endtask

   task automatic test_random_streams();
      int               sent;
      int               len;
      int               r;
      sample_style_type style;
      sent = 0;
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0:       set_file_size($urandom_range(0, 20000));
            1:       set_file_size(32'hFC00_0000 | 32'(2**FSIZE_W - 1));
            2:       set_file_size(32'h1);
            3:       set_file_size($urandom);
            4:       set_file_size($urandom_range(0, 2000));
            default: set_file_size(32'h0);
         endcase
         calm = (seg % 3 == 2);
         while (sent < (seg + 1) * 280) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               len = $urandom_range(1, 12);
            else if (r < 95)
               len = $urandom_range(13, 80);
            else
               len = $urandom_range(81, 300);
            style = sample_style_type'($urandom_range(0, 3));
            send_stream(len, style);
            sent += len;
         end
         drain();
      end
      calm = 1'b0;
   endtask

   // Hold the result side off while streams keep arriving, so input backs up.
   task automatic test_backpressure();
      set_file_size($urandom_range(100, 5000));
      hold_cycles = 400;
      for (int i = 0; i < 6; i++)
         send_stream($urandom_range(4, 12), SMP_FULL);
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_register();
      test_extremes();
      test_random_streams();
      test_backpressure();
      $display("run covered %0d samples in %0d streams, %0d level results checked",
               samples_sent, streams_sent, levels_checked);
      $display("file size settings: %0d, with read-back of each", size_settings);
      if (mismatch_count == 0 && pending_levels.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/prbm_pkg.sv
hw/rtl/peak_rms_bitrate_meter.sv
tb/testbench.sv
